>>> rtl/mfrd_pkg.sv
`default_nettype none
package mfrd_pkg;

  localparam int unsigned PANEL_WIDTH  = 240;
  localparam int unsigned PANEL_HEIGHT = 160;
  localparam int unsigned PIXEL_TOTAL  = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned STORE_WORDS  = (PIXEL_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W       = $clog2(STORE_WORDS);
  localparam int unsigned BIT_W        = $clog2(WORD_BITS);
  localparam int unsigned COORD_W      = 8;
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned GROUP_W      = 14;
  localparam int unsigned GROUP_LEN    = 3;
  // pixel index reach of a group read: last group, last pixel
  localparam int unsigned PIX_W        = $clog2(((1 << GROUP_W) - 1) * GROUP_LEN + GROUP_LEN);
  localparam int unsigned DWORD_W      = 16;

  localparam logic [DWORD_W-1:0] WORD_PIX0 = 16'hF800;
  localparam logic [DWORD_W-1:0] WORD_PIX1 = 16'h0780;
  localparam logic [DWORD_W-1:0] WORD_PIX2 = 16'h001F;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PIXEL   = 3'd0,
    FUNC_OUTLINE = 3'd1,
    FUNC_FILL    = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_READ    = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RD,
    ST_WR,
    ST_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic               valid;
    logic [DWORD_W-1:0] display_word;
    logic               clipped;
  } result_t;

  // panel word contribution of pixel k within a group
  function automatic logic [DWORD_W-1:0] group_pattern(input logic [1:0] k);
    logic [DWORD_W-1:0] p;
    case (k)
      2'd0:    p = WORD_PIX0;
      2'd1:    p = WORD_PIX1;
      2'd2:    p = WORD_PIX2;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mfrd_ifs.sv
`default_nettype none
interface mfrd_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [mfrd_pkg::FUNC_W-1:0]         func;
  logic [mfrd_pkg::COORD_W-1:0]        x_first;
  logic [mfrd_pkg::COORD_W-1:0]        y_first;
  logic [mfrd_pkg::COORD_W-1:0]        x_second;
  logic [mfrd_pkg::COORD_W-1:0]        y_second;
  logic                                color;
  logic [mfrd_pkg::GROUP_W-1:0]        group_index;

  modport source (output valid, func, x_first, y_first, x_second, y_second, color,
                  group_index, input ready);
  modport sink   (input valid, func, x_first, y_first, x_second, y_second, color,
                  group_index, output ready);
endinterface

interface mfrd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mfrd_pkg::DWORD_W-1:0]  display_word;
  logic                          clipped;

  modport source (output valid, display_word, clipped, input ready);
  modport sink   (input valid, display_word, clipped, output ready);
endinterface
`default_nettype wire

>>> rtl/mfrd_store.sv
`default_nettype none
module mfrd_store (
  input  logic                                clk_i,
  input  mfrd_pkg::mem_req_t                  req_i,
  output logic [mfrd_pkg::WORD_BITS-1:0]      rdata_o
);

  logic [mfrd_pkg::WORD_BITS-1:0] mem [mfrd_pkg::STORE_WORDS];
  logic [mfrd_pkg::WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/mfrd_seq.sv
`default_nettype none
module mfrd_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mfrd_cmd_if.sink                        cmd_i,
  input  logic                            out_free_i,
  input  logic [mfrd_pkg::WORD_BITS-1:0]  rdata_i,
  output mfrd_pkg::mem_req_t              mem_req_o,
  output mfrd_pkg::result_t               result_o
);

  localparam logic [mfrd_pkg::COORD_W-1:0] W_C =
    mfrd_pkg::COORD_W'(mfrd_pkg::PANEL_WIDTH);
  localparam logic [mfrd_pkg::COORD_W-1:0] H_C =
    mfrd_pkg::COORD_W'(mfrd_pkg::PANEL_HEIGHT);
  localparam logic [mfrd_pkg::PIX_W-1:0] TOTAL_C =
    mfrd_pkg::PIX_W'(mfrd_pkg::PIXEL_TOTAL);
  localparam logic [mfrd_pkg::ADDR_W-1:0] CLR_LAST_C =
    mfrd_pkg::ADDR_W'(mfrd_pkg::STORE_WORDS - 1);
  localparam logic [mfrd_pkg::COORD_W-1:0] GROUP_LAST_C =
    mfrd_pkg::COORD_W'(mfrd_pkg::GROUP_LEN - 1);

  mfrd_pkg::state_e state_q, state_d;
  mfrd_pkg::func_e  func_q;

  logic [mfrd_pkg::COORD_W-1:0]   x0_q, x1_q, y0_q, y1_q, xe_q, ye_q, x_q, y_q;
  logic                           fill_q, color_q, hit_q, clipped_q, clr_cmd_q;
  logic [mfrd_pkg::PIX_W-1:0]     base_q;
  logic [mfrd_pkg::BIT_W-1:0]     bit_q;
  logic [mfrd_pkg::ADDR_W-1:0]    addr_q, clr_q;
  logic [mfrd_pkg::DWORD_W-1:0]   word_q;

  logic                           accept;
  logic [mfrd_pkg::COORD_W-1:0]   xa, xb, ya, yb;
  logic [mfrd_pkg::PIX_W-1:0]     pix, tri3;
  logic                           pix_in, edge_row, row_end, last_row;
  logic [mfrd_pkg::WORD_BITS-1:0] bit_mask;

  assign cmd_i.ready = (state_q == mfrd_pkg::ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign xa = cmd_i.x_first;
  assign ya = cmd_i.y_first;
  assign xb = cmd_i.x_second;
  assign yb = cmd_i.y_second;

  // shared pixel address adder: row base plus column (or group base plus offset)
  assign pix      = base_q + mfrd_pkg::PIX_W'(x_q);
  assign pix_in   = pix < TOTAL_C;
  assign tri3     = base_q + {base_q[mfrd_pkg::PIX_W-2:0], 1'b0};
  assign bit_mask = mfrd_pkg::WORD_BITS'(1) << bit_q;

  // outline middle rows visit only first and last column
  assign edge_row = fill_q || (y_q == y0_q) || (y_q == y1_q);
  assign row_end  = (x_q == xe_q) || (!edge_row && (x1_q != xe_q));
  assign last_row = (y_q == ye_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mfrd_pkg::ST_CLEAR;
      clr_q     <= '0;
      clr_cmd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        clr_q     <= '0;
        clr_cmd_q <= 1'b1;
      end else if (state_q == mfrd_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mfrd_pkg::ST_IDLE: begin
        if (accept) begin
          func_q    <= mfrd_pkg::func_e'(cmd_i.func);
          fill_q    <= (cmd_i.func != mfrd_pkg::FUNC_OUTLINE);
          color_q   <= cmd_i.color;
          word_q    <= '0;
          clipped_q <= 1'b0;
          base_q    <= mfrd_pkg::PIX_W'(cmd_i.group_index);
          if (cmd_i.func == mfrd_pkg::FUNC_PIXEL) begin
            x0_q <= xa;
            x1_q <= xa;
            y0_q <= ya;
            y1_q <= ya;
          end else begin
            x0_q <= (xa < xb) ? xa : xb;
            x1_q <= (xa < xb) ? xb : xa;
            y0_q <= (ya < yb) ? ya : yb;
            y1_q <= (ya < yb) ? yb : ya;
          end
        end
      end
      mfrd_pkg::ST_SETUP: begin
        if (func_q == mfrd_pkg::FUNC_READ) begin
          base_q    <= tri3;
          x_q       <= '0;
          clipped_q <= tri3 >= (TOTAL_C - mfrd_pkg::PIX_W'(mfrd_pkg::GROUP_LEN - 1));
        end else if (func_q == mfrd_pkg::FUNC_PIXEL || func_q == mfrd_pkg::FUNC_OUTLINE
                     || func_q == mfrd_pkg::FUNC_FILL) begin
          base_q    <= mfrd_pkg::PIX_W'(y0_q) * mfrd_pkg::PIX_W'(mfrd_pkg::PANEL_WIDTH);
          x_q       <= x0_q;
          y_q       <= y0_q;
          xe_q      <= (x1_q >= W_C) ? (W_C - 1'b1) : x1_q;
          ye_q      <= (y1_q >= H_C) ? (H_C - 1'b1) : y1_q;
          clipped_q <= (x1_q >= W_C) || (y1_q >= H_C);
        end
      end
      mfrd_pkg::ST_RD: begin
        bit_q  <= pix[mfrd_pkg::BIT_W-1:0];
        addr_q <= pix[mfrd_pkg::BIT_W +: mfrd_pkg::ADDR_W];
        hit_q  <= pix_in;
      end
      mfrd_pkg::ST_CHK: begin
        if (hit_q && rdata_i[bit_q]) begin
          word_q <= word_q | mfrd_pkg::group_pattern(x_q[1:0]);
        end
        x_q <= x_q + 1'b1;
      end
      mfrd_pkg::ST_WR: begin
        if (row_end) begin
          x_q    <= x0_q;
          y_q    <= y_q + 1'b1;
          base_q <= base_q + mfrd_pkg::PIX_W'(mfrd_pkg::PANEL_WIDTH);
        end else begin
          x_q <= edge_row ? (x_q + 1'b1) : x1_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d         = state_q;
    mem_req_o       = '0;
    result_o        = '0;
    result_o.display_word = word_q;
    result_o.clipped      = clipped_q;
    case (state_q)
      mfrd_pkg::ST_CLEAR: begin
        mem_req_o.wr   = 1'b1;
        mem_req_o.addr = clr_q;
        if (clr_q == CLR_LAST_C) begin
          state_d = clr_cmd_q ? mfrd_pkg::ST_DONE : mfrd_pkg::ST_IDLE;
        end
      end
      mfrd_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = mfrd_pkg::ST_SETUP;
        end
      end
      mfrd_pkg::ST_SETUP: begin
        case (func_q)
          mfrd_pkg::FUNC_READ:  state_d = mfrd_pkg::ST_RD;
          mfrd_pkg::FUNC_CLEAR: state_d = mfrd_pkg::ST_CLEAR;
          mfrd_pkg::FUNC_PIXEL, mfrd_pkg::FUNC_OUTLINE, mfrd_pkg::FUNC_FILL: begin
            state_d = ((x0_q < W_C) && (y0_q < H_C)) ? mfrd_pkg::ST_RD : mfrd_pkg::ST_DONE;
          end
          default: state_d = mfrd_pkg::ST_DONE;
        endcase
      end
      mfrd_pkg::ST_RD: begin
        mem_req_o.rd   = (func_q == mfrd_pkg::FUNC_READ) ? pix_in : 1'b1;
        mem_req_o.addr = pix[mfrd_pkg::BIT_W +: mfrd_pkg::ADDR_W];
        state_d = (func_q == mfrd_pkg::FUNC_READ) ? mfrd_pkg::ST_CHK : mfrd_pkg::ST_WR;
      end
      mfrd_pkg::ST_CHK: begin
        state_d = (x_q == GROUP_LAST_C) ? mfrd_pkg::ST_DONE : mfrd_pkg::ST_RD;
      end
      mfrd_pkg::ST_WR: begin
        mem_req_o.wr    = 1'b1;
        mem_req_o.addr  = addr_q;
        mem_req_o.wdata = color_q ? (rdata_i | bit_mask) : (rdata_i & ~bit_mask);
        state_d = (row_end && last_row) ? mfrd_pkg::ST_DONE : mfrd_pkg::ST_RD;
      end
      mfrd_pkg::ST_DONE: begin
        if (out_free_i) begin
          result_o.valid = 1'b1;
          state_d        = mfrd_pkg::ST_IDLE;
        end
      end
      default: state_d = mfrd_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/mono_framebuffer_rect_draw.sv
// 240x160 one-bit frame store with pixel, rectangle outline, filled
// rectangle, clear and three-pixel group read commands; one result beat per
// command beat. Commands run one at a time: cmd_i.ready is high only while
// the sequencer is idle. Every frame store access goes through one word
// port of a 1200x32 memory and one pixel address adder, so cost is set by
// that port: a single pixel is a read and then a write of its word, a
// rectangle a read and a write per on-panel pixel it touches (outline
// middle rows visit only their two end columns), a group read a read and
// a check per pixel, and a clear a write of every word. After reset the
// store is swept to zero, one word a cycle, before the first command beat
// is taken. Off-panel pixels are skipped without a memory access and raise
// clipped. The result sits in an output register, so a new command is
// taken while the previous result still waits on rsp_o.
`default_nettype none
module mono_framebuffer_rect_draw (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfrd_cmd_if.sink    cmd_i,
  mfrd_rsp_if.source  rsp_o
);

  mfrd_pkg::mem_req_t             mem_req;
  mfrd_pkg::result_t              result;
  logic [mfrd_pkg::WORD_BITS-1:0] rdata;

  logic                           out_valid_q;
  logic [mfrd_pkg::DWORD_W-1:0]   out_word_q;
  logic                           out_clip_q;
  logic                           out_free;

  // slot is free when empty or when its beat leaves this cycle
  assign out_free = !out_valid_q || rsp_o.ready;

  mfrd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .out_free_i (out_free),
    .rdata_i    (rdata),
    .mem_req_o  (mem_req),
    .result_o   (result)
  );

  mfrd_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      out_word_q <= result.display_word;
      out_clip_q <= result.clipped;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.display_word = out_word_q;
  assign rsp_o.clipped      = out_clip_q;

endmodule
`default_nettype wire
